### rtl/isrt_pkg.sv
// Shared types and constants for the introspective sorter.
// Used by the sorting cell, the top level and the port checker.
`default_nettype none

package isrt_pkg;

  // Number of cells in the chain, which is also the largest set that can be held.
  localparam int unsigned NUM_CELLS = 64;
  localparam int unsigned DATA_W    = 32;

  // Sequencer states with one-hot codes.
  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } isrt_state_t;

  // Control that is broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                     ins;   // insert x into the sorted chain
    logic                     shl;   // shift the chain toward cell 0
    logic signed [DATA_W-1:0] x;     // value being inserted
  } isrt_ctrl_t;

endpackage

`default_nettype wire

### rtl/isrt_cell.sv
// One cell of the sorting chain: holds one element and its valid flag.
// Depends on isrt_pkg for the data width and the control struct.
`default_nettype none

module isrt_cell
  import isrt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire isrt_ctrl_t               ctrl,
  // Left neighbor, toward smaller values.
  input  wire logic signed [DATA_W-1:0] left_val,
  input  wire logic                     left_vld,
  input  wire logic                     left_gt,
  // Right neighbor, toward greater values.
  input  wire logic signed [DATA_W-1:0] right_val,
  input  wire logic                     right_vld,
  // This cell.
  output logic signed [DATA_W-1:0]      val,
  output logic                          vld,
  output logic                          gt
);

  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     vld_r, vld_nxt;

  // An empty cell counts as greater than any value.
  assign gt = !vld_r || (val_r > ctrl.x);

  // On an insertion, cells past the insertion point take their left
  // neighbor, the cell at the insertion point takes x, and the others hold.
  // On a shift, every cell takes its right neighbor.
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctrl.shl) begin
      val_nxt = right_val;
      vld_nxt = right_vld;
    end else if (ctrl.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
        vld_nxt = left_vld;
      end else if (gt) begin
        val_nxt = ctrl.x;
        vld_nxt = 1'b1;
      end
    end
  end

  // The valid flag is control state; the value needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

`default_nettype wire

### rtl/introspective_sorter.sv
// Streaming sorter of signed 32-bit values: top level with sequencer,
// output register and the cell chain. Depends on isrt_pkg and isrt_cell.
//
// Values arrive one transaction per cycle while in_stall is low and are
// inserted into a chain of 64 cells that always holds them in ascending
// signed order. A transaction with in_last set ends the set; input is then
// stalled while the chain shifts toward cell 0 and the smallest value moves
// into the output register on each cycle the output is not stalled. New
// input is taken again in the cycle after the final result is loaded into
// the output register. Values beyond 64 in one set are dropped; duplicates
// are kept, and the greatest value carries out_last_res.
`default_nettype none

module introspective_sorter
  import isrt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic                     in_last,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_value_res,
  output logic                          out_last_res
);

  isrt_state_t state_r, state_nxt;
  isrt_ctrl_t  ctrl;

  logic                     in_acc;
  logic                     out_free;
  logic                     full;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;

  // Chain links; cell i drives index i+1, the ends are tied off.
  logic signed [DATA_W-1:0] cval [0:NUM_CELLS+1];
  logic                     cvld [0:NUM_CELLS+1];
  logic                     cgt  [0:NUM_CELLS];

  assign cval[0]           = '0;
  assign cvld[0]           = 1'b0;
  assign cgt[0]            = 1'b0;
  assign cval[NUM_CELLS+1] = '0;
  assign cvld[NUM_CELLS+1] = 1'b0;

  // Handshake and broadcast control.
  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign full     = cvld[NUM_CELLS];
  assign out_free = !out_valid_r || !out_stall;

  assign ctrl.ins = in_acc && !full;
  assign ctrl.shl = (state_r == ST_EMIT) && out_free;
  assign ctrl.x   = in_value;

  // Row of cells.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    isrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_val  (cval[i]),
      .left_vld  (cvld[i]),
      .left_gt   (cgt[i]),
      .right_val (cval[i+2]),
      .right_vld (cvld[i+2]),
      .val       (cval[i+1]),
      .vld       (cvld[i+1]),
      .gt        (cgt[i+1])
    );
  end

  // Sequencer and output register.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          // The smallest held value leaves cell 0; it is the final one when
          // cell 1 is empty.
          out_value_nxt = cval[1];
          out_last_nxt  = !cvld[2];
          if (!cvld[2]) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
    if (ctrl.shl) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;

endmodule

`default_nettype wire

### rtl/isrt_checker.sv
// Port-level checks for the introspective sorter, bound to the top level.
// Depends on isrt_pkg for the data width.
`default_nettype none

module isrt_checker
  import isrt_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic signed [DATA_W-1:0] in_value,
  input wire logic                     in_last,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic signed [DATA_W-1:0] out_value_res,
  input wire logic                     out_last_res
);

  // No result is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_res)
                              && $stable(out_last_res))
    else $error("stalled result changed");

  // The transaction that ends a set stops further input.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input taken after the final element of a set");

  // While a result that is not the final one is pending, input stays blocked.
  a_emit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_res |-> in_stall)
    else $error("input taken in the middle of a sorted run");

endmodule

bind introspective_sorter isrt_checker u_isrt_checker (.*);

`default_nettype wire
